[sv/clmf_pkg.sv]
package clmf_pkg;

    // Grid and datapath sizing
    localparam int MAX_PHI     = 128;
    localparam int MAX_ETA     = 64;
    localparam int ENERGY_BITS = 16;

    localparam int PHI_IDX_W = $clog2(MAX_PHI);        // line store address
    localparam int PHI_CNT_W = $clog2(MAX_PHI + 1);    // holds MAX_PHI itself
    localparam int ROW_W     = $clog2(MAX_ETA + 2);    // row runs up to eta + 1

    // Fixed widths of the register and result fields
    localparam int GRID_PHI_W = 8;
    localparam int GRID_ETA_W = 7;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int ETA_W      = 6;
    localparam int PHI_W      = 7;

    localparam logic [GRID_PHI_W-1:0] GRID_PHI_RESET = GRID_PHI_W'(72);
    localparam logic [GRID_ETA_W-1:0] GRID_ETA_RESET = GRID_ETA_W'(56);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_PHI,
        REG_GRID_ETA
    } cfg_reg_t;

    typedef struct packed {
        logic                   present;
        logic [ENERGY_BITS-1:0] seed;
        logic [ENERGY_BITS-1:0] total;
    } cell_t;

    localparam int    CELL_W      = $bits(cell_t);
    localparam cell_t CELL_ABSENT = '0;

    // [eta-1, eta, eta+1][phi-1, phi, phi+1]
    typedef cell_t [2:0][2:0] window_t;

    // Per-item control carried from the input register to the window stage
    typedef struct packed {
        logic                 ign;       // beyond the drain, no effect
        logic                 clear;     // first item of a new frame
        logic                 zero_col;  // column 0: closes the previous row
        logic                 judge_ok;  // centre lies inside the grid
        logic [ETA_W-1:0]     eta;
        logic [PHI_W-1:0]     phi;
        logic [PHI_IDX_W-1:0] col;
    } stage_ctl_t;

endpackage

[sv/clmf_line_store.sv]
module clmf_line_store import clmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 rd_en,
    input  logic [PHI_IDX_W-1:0] rd_addr,
    output cell_t                rd_upper,
    output cell_t                rd_middle,
    input  logic                 wr_en,
    input  logic [PHI_IDX_W-1:0] wr_addr,
    input  cell_t                wr_upper,
    input  cell_t                wr_middle
);

    logic [2*CELL_W-1:0] line_reg [MAX_PHI];
    logic [2*CELL_W-1:0] rd_data_reg;
    logic [MAX_PHI-1:0]  valid_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_reg[wr_addr] <= {wr_upper, wr_middle};
        end
        if (rd_en)
        begin
            rd_data_reg <= line_reg[rd_addr];
        end
    end

    // clear wins over a write landing on the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= !clear && valid_reg[rd_addr];
            end
        end
    end

    assign rd_upper  = rd_valid_reg ? cell_t'(rd_data_reg[2*CELL_W-1:CELL_W]) : CELL_ABSENT;
    assign rd_middle = rd_valid_reg ? cell_t'(rd_data_reg[CELL_W-1:0]) : CELL_ABSENT;

endmodule

[sv/clmf_window.sv]
module clmf_window import clmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 cfg_clear,
    input  logic                 s1_valid,
    input  stage_ctl_t           s1_ctl,
    input  cell_t                s1_cell,
    input  cell_t                up_cell,
    input  cell_t                mid_cell,
    output logic                 wr_en,
    output logic [PHI_IDX_W-1:0] wr_addr,
    output cell_t                wr_upper,
    output cell_t                wr_middle,
    output logic                 s2_valid,
    output logic [ETA_W-1:0]     s2_eta,
    output logic [PHI_W-1:0]     s2_phi,
    output window_t              s2_win
);

    window_t          win_reg;
    window_t          win_next;
    window_t          win_cur;
    window_t          judged;
    cell_t [2:0]      new_col;
    logic             step;
    logic             s2_valid_reg;
    logic [ETA_W-1:0] s2_eta_reg;
    logic [PHI_W-1:0] s2_phi_reg;
    window_t          s2_win_reg;

    assign step = en && s1_valid && !s1_ctl.ign;

    always_comb
    begin
        win_cur    = s1_ctl.clear ? window_t'('0) : win_reg;
        new_col[0] = up_cell;
        new_col[1] = mid_cell;
        new_col[2] = s1_cell;
        for (int i = 0; i < 3; i++)
        begin
            if (s1_ctl.zero_col)
            begin
                // absent column closes the previous row, then the new column
                judged[i][0]   = win_cur[i][1];
                judged[i][1]   = win_cur[i][2];
                judged[i][2]   = CELL_ABSENT;
                win_next[i][0] = win_cur[i][2];
                win_next[i][1] = CELL_ABSENT;
                win_next[i][2] = new_col[i];
            end
            else
            begin
                win_next[i][0] = win_cur[i][1];
                win_next[i][1] = win_cur[i][2];
                win_next[i][2] = new_col[i];
                judged[i]      = win_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_clear)
            begin
                win_reg <= '0;
            end
            else if (step)
            begin
                win_reg <= win_next;
            end
            if (en)
            begin
                s2_valid_reg <= s1_valid && !s1_ctl.ign && s1_ctl.judge_ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_eta_reg <= s1_ctl.eta;
            s2_phi_reg <= s1_ctl.phi;
            s2_win_reg <= judged;
        end
    end

    // line store column shifts down: middle -> upper, incoming -> middle
    assign wr_en     = step;
    assign wr_addr   = s1_ctl.col;
    assign wr_upper  = mid_cell;
    assign wr_middle = s1_cell;

    assign s2_valid = s2_valid_reg;
    assign s2_eta   = s2_eta_reg;
    assign s2_phi   = s2_phi_reg;
    assign s2_win   = s2_win_reg;

endmodule

[sv/clmf_judge.sv]
module clmf_judge import clmf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   s2_valid,
    input  logic [ETA_W-1:0]       s2_eta,
    input  logic [PHI_W-1:0]       s2_phi,
    input  window_t                s2_win,
    output logic                   out_valid,
    output logic [ETA_W-1:0]       out_eta,
    output logic [PHI_W-1:0]       out_phi,
    output logic [ENERGY_BITS-1:0] out_seed_energy,
    output logic [ENERGY_BITS-1:0] out_total_energy
);

    cell_t                  ctr;
    cell_t                  nb;
    logic                   sup;
    logic                   tie_wins;
    logic                   keep;
    logic                   out_valid_reg;
    logic [ETA_W-1:0]       out_eta_reg;
    logic [PHI_W-1:0]       out_phi_reg;
    logic [ENERGY_BITS-1:0] out_seed_reg;
    logic [ENERGY_BITS-1:0] out_total_reg;

    // eight neighbour compares in parallel
    always_comb
    begin
        ctr = s2_win[1][1];
        sup = 1'b0;
        nb  = CELL_ABSENT;
        tie_wins = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                nb       = s2_win[i][j];
                // full tie goes to the neighbour at eta+1, or same eta at phi+1
                tie_wins = (i == 2) || (i == 1 && j == 2);
                if (!(i == 1 && j == 1) && nb.present)
                begin
                    if (nb.seed > ctr.seed)
                    begin
                        sup = 1'b1;
                    end
                    else if (nb.seed == ctr.seed)
                    begin
                        if (nb.total > ctr.total)
                        begin
                            sup = 1'b1;
                        end
                        else if (nb.total == ctr.total && tie_wins)
                        begin
                            sup = 1'b1;
                        end
                    end
                end
            end
        end
        keep = s2_valid && ctr.present && !sup;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && keep)
        begin
            out_eta_reg   <= s2_eta;
            out_phi_reg   <= s2_phi;
            out_seed_reg  <= ctr.seed;
            out_total_reg <= ctr.total;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_eta          = out_eta_reg;
    assign out_phi          = out_phi_reg;
    assign out_seed_energy  = out_seed_reg;
    assign out_total_energy = out_total_reg;

endmodule

[sv/cluster_local_max_filter_3x3_unit.sv]
// Throughput: one item per cycle unless out_ready stalls the pipe; the eight neighbour compares run in parallel.
// Pipeline: the item that decides a result passes the input register, the window stage
//   and the compare stage into the result register.
// Reset (async, rst_n low): grid_phi = 72, grid_eta = 56, counters and window
//   cleared, line store valid bits cleared at once; no clearing pass.
module cluster_local_max_filter_3x3_unit import clmf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cell_present,
    input  logic [ENERGY_BITS-1:0] seed_energy,
    input  logic [ENERGY_BITS-1:0] total_energy,
    input  logic                   flush,
    // result items
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ETA_W-1:0]       out_eta,
    output logic [PHI_W-1:0]       out_phi,
    output logic [ENERGY_BITS-1:0] out_seed_energy,
    output logic [ENERGY_BITS-1:0] out_total_energy
);

    // config registers and clamped grid size
    logic [GRID_PHI_W-1:0] grid_phi_reg;
    logic [GRID_ETA_W-1:0] grid_eta_reg;
    logic [PHI_CNT_W-1:0]  nphi;
    logic [ROW_W-1:0]      neta;
    logic [ROW_W-1:0]      neta_p1;

    // raster position
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [PHI_IDX_W-1:0] col_reg;
    logic [PHI_IDX_W-1:0] col_next;

    logic                 en;
    logic                 accept;
    logic                 new_frame;
    logic [ROW_W-1:0]     r;
    logic [PHI_IDX_W-1:0] cc;
    logic [PHI_CNT_W-1:0] col_inc;
    stage_ctl_t           ctl;
    cell_t                inc;

    // input register
    logic       s1_valid_reg;
    stage_ctl_t s1_ctl_reg;
    cell_t      s1_cell_reg;

    // line store and window wiring
    cell_t                up_cell;
    cell_t                mid_cell;
    logic                 ls_clear;
    logic                 wr_en;
    logic [PHI_IDX_W-1:0] wr_addr;
    cell_t                wr_upper;
    cell_t                wr_middle;
    logic                 s2_valid;
    logic [ETA_W-1:0]     s2_eta;
    logic [PHI_W-1:0]     s2_phi;
    window_t              s2_win;

    // whole pipe advances whenever the result register is free or being taken
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    always_comb
    begin
        if (grid_phi_reg < GRID_PHI_W'(3))
        begin
            nphi = PHI_CNT_W'(3);
        end
        else if (PHI_CNT_W'(grid_phi_reg) > PHI_CNT_W'(MAX_PHI))
        begin
            nphi = PHI_CNT_W'(MAX_PHI);
        end
        else
        begin
            nphi = PHI_CNT_W'(grid_phi_reg);
        end

        if (grid_eta_reg < GRID_ETA_W'(3))
        begin
            neta = ROW_W'(3);
        end
        else if (ROW_W'(grid_eta_reg) > ROW_W'(MAX_ETA))
        begin
            neta = ROW_W'(MAX_ETA);
        end
        else
        begin
            neta = ROW_W'(grid_eta_reg);
        end
        neta_p1 = neta + ROW_W'(1);
    end

    // position of this item, frame restart, drain end
    always_comb
    begin
        new_frame = !flush && (row_reg >= neta);
        r         = new_frame ? '0 : row_reg;
        cc        = new_frame ? '0 : col_reg;
        if (PHI_CNT_W'(cc) >= nphi)
        begin
            cc = '0;
        end

        ctl          = '0;
        ctl.clear    = new_frame;
        ctl.ign      = (r > neta_p1) || (r == neta_p1 && cc != '0);
        ctl.zero_col = (cc == '0);
        ctl.col      = cc;
        if (ctl.zero_col)
        begin
            // last cell of the row before the previous one
            ctl.judge_ok = (r >= ROW_W'(2));
            ctl.eta      = ETA_W'(r - ROW_W'(2));
            ctl.phi      = PHI_W'(nphi - PHI_CNT_W'(1));
        end
        else
        begin
            ctl.judge_ok = (r >= ROW_W'(1)) && (r <= neta);
            ctl.eta      = ETA_W'(r - ROW_W'(1));
            ctl.phi      = PHI_W'(cc - PHI_IDX_W'(1));
        end

        col_inc  = PHI_CNT_W'(cc) + PHI_CNT_W'(1);
        row_next = row_reg;
        col_next = col_reg;
        if (accept && !ctl.ign)
        begin
            if (col_inc >= nphi)
            begin
                col_next = '0;
                row_next = r + ROW_W'(1);
            end
            else
            begin
                col_next = PHI_IDX_W'(col_inc);
                row_next = r;
            end
        end

        // flush cells count as absent
        inc         = CELL_ABSENT;
        inc.present = cell_present && !flush;
        if (inc.present)
        begin
            inc.seed  = seed_energy;
            inc.total = total_energy;
        end
    end

    // config writes: any write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_phi_reg <= GRID_PHI_RESET;
            grid_eta_reg <= GRID_ETA_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GRID_PHI: grid_phi_reg <= GRID_PHI_W'(cfg_wdata);
                    REG_GRID_ETA: grid_eta_reg <= cfg_wdata[GRID_ETA_W-1:0];
                endcase
                row_reg <= '0;
                col_reg <= '0;
            end
            else
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (en)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg  <= ctl;
            s1_cell_reg <= inc;
        end
    end

    assign ls_clear = cfg_we || (accept && new_frame);

    clmf_line_store u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (ls_clear),
        .rd_en     (accept),
        .rd_addr   (cc),
        .rd_upper  (up_cell),
        .rd_middle (mid_cell),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle)
    );

    clmf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg_clear (cfg_we),
        .s1_valid  (s1_valid_reg),
        .s1_ctl    (s1_ctl_reg),
        .s1_cell   (s1_cell_reg),
        .up_cell   (up_cell),
        .mid_cell  (mid_cell),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle),
        .s2_valid  (s2_valid),
        .s2_eta    (s2_eta),
        .s2_phi    (s2_phi),
        .s2_win    (s2_win)
    );

    clmf_judge u_judge (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .s2_valid         (s2_valid),
        .s2_eta           (s2_eta),
        .s2_phi           (s2_phi),
        .s2_win           (s2_win),
        .out_valid        (out_valid),
        .out_eta          (out_eta),
        .out_phi          (out_phi),
        .out_seed_energy  (out_seed_energy),
        .out_total_energy (out_total_energy)
    );

endmodule
